>>> rtl/core/imu_euler_frame_parser_unit_macros.svh
// assertion macros used by the checker file of the euler frame parser
// every macro samples on clk and is disabled while arst_n is low
`ifndef IMU_EULER_FRAME_PARSER_UNIT_MACROS_SVH
`define IMU_EULER_FRAME_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define IEFP_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IEFP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/iefp_pkg.sv
// shared types and constants of the euler frame parser
// no dependencies
package iefp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h7E;
	localparam logic [7:0] HDR_SECOND = 8'h23;
	localparam logic [7:0] CODE_EULER = 8'h26;
	localparam logic [7:0] MIN_LEN    = 8'd7;
	localparam logic [7:0] EULER_LEN  = 8'd17;

	// round(180/pi * 2^32), split for two narrow multipliers
	localparam logic [37:0] RAD2DEG_Q32 = 38'd246083499208;
	localparam int          K_LO_W      = 19;
	localparam logic [18:0] K_HI        = RAD2DEG_Q32[37:19];
	localparam logic [18:0] K_LO        = RAD2DEG_Q32[18:0];

	localparam logic [31:0] Q16_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q16_NEG_MAX = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] yaw;
		logic [31:0] pitch;
		logic [31:0] roll;
	} frame_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

>>> rtl/core/imu_euler_frame_parser_unit.sv
// Euler frame parser: takes one received byte per cycle on the s_ side (tlast marks the end of
// a receive burst) and emits roll, pitch and yaw in signed Q16.16 degrees on the m_ side, with
// the saturation flag in tuser. The byte parser keeps pace with the stream at one byte per
// cycle; once its checksum byte is taken, a result passes through a four-stage conversion
// pipeline whose last stage is the output register. Input is held off only while all four
// conversion stages hold results and the output is stalled. No clearing pass after reset:
// the block is ready in the first cycle.
// depends on iefp_pkg, iefp_parser and iefp_conv_lane
module imu_euler_frame_parser_unit import iefp_pkg::*; #(
	parameter int unsigned MAX_FRAME_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] roll_deg, [63:32] pitch_deg, [95:64] yaw_deg
	output logic [0:0]  m_tuser    // [0] saturated
);

	logic      accept;
	logic      frame_ok;
	frame_t    frame;
	stage_en_t en;
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      rdy1, rdy2, rdy3, rdy4;
	logic      sat_roll, sat_pitch, sat_yaw;

	assign rdy4     = !v_s4 || m_tready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && rdy1;

	iefp_parser #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (s_tdata),
		.burst_end(s_tlast),
		.frame_ok (frame_ok),
		.frame    (frame)
	);

	assign en.s1 = rdy1 && frame_ok;
	assign en.s2 = rdy2 && v_s1;
	assign en.s3 = rdy3 && v_s2;
	assign en.s4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= frame_ok;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
			if (rdy4)
				v_s4 <= v_s3;
		end
	end

	iefp_conv_lane u_roll (
		.clk (clk),
		.en  (en),
		.word(frame.roll),
		.q16 (m_tdata[31:0]),
		.sat (sat_roll)
	);

	iefp_conv_lane u_pitch (
		.clk (clk),
		.en  (en),
		.word(frame.pitch),
		.q16 (m_tdata[63:32]),
		.sat (sat_pitch)
	);

	iefp_conv_lane u_yaw (
		.clk (clk),
		.en  (en),
		.word(frame.yaw),
		.q16 (m_tdata[95:64]),
		.sat (sat_yaw)
	);

	assign m_tvalid   = v_s4;
	assign m_tuser[0] = sat_roll || sat_pitch || sat_yaw;

endmodule

>>> rtl/core/iefp_parser.sv
// byte-level frame parser: header hunt, length check, running checksum, payload capture
// depends on iefp_pkg
module iefp_parser import iefp_pkg::*; #(
	parameter int unsigned MAX_FRAME_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  logic       burst_end,
	output logic       frame_ok,
	output frame_t     frame
);

	typedef enum logic [3:0] {
		PH_HUNT1 = 4'b0001,
		PH_HUNT2 = 4'b0010,
		PH_LEN   = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] len_q, len_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] code_q, code_d;
	logic [7:0] payload_q [12];
	logic       pay_we;
	logic [3:0] pay_idx;
	logic       last_byte;

	assign last_byte = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};
	assign pay_idx   = 4'(pos_q - 8'd4);

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		pos_d   = pos_q;
		sum_d   = sum_q;
		code_d  = code_q;
		pay_we  = 1'b0;
		unique case (phase_q)
			PH_HUNT1: begin
				if (rx_byte == HDR_FIRST) begin
					sum_d   = rx_byte;
					phase_d = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				if (rx_byte == HDR_SECOND) begin
					sum_d   = sum_q + rx_byte;
					phase_d = PH_LEN;
				end else if (rx_byte == HDR_FIRST) begin
					sum_d = rx_byte;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_LEN: begin
				if (rx_byte < MIN_LEN || rx_byte > 8'(MAX_FRAME_LEN)) begin
					phase_d = PH_HUNT1;
				end else begin
					len_d   = rx_byte;
					sum_d   = sum_q + rx_byte;
					pos_d   = 8'd3;
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				if (last_byte) begin
					phase_d = PH_HUNT1;
				end else begin
					sum_d = sum_q + rx_byte;
					if (pos_q == 8'd3)
						code_d = rx_byte;
					pay_we = (pos_q >= 8'd4) && (pos_q <= 8'd15);
					pos_d  = pos_q + 8'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
		if (burst_end)
			phase_d = PH_HUNT1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			len_q   <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
			code_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			code_q  <= code_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pay_we)
			payload_q[pay_idx] <= rx_byte;
	end

	assign frame_ok = accept && (phase_q == PH_BODY) && last_byte && (rx_byte == sum_q)
		&& (code_q == CODE_EULER) && (len_q >= EULER_LEN);

	assign frame.roll  = {payload_q[3], payload_q[2], payload_q[1], payload_q[0]};
	assign frame.pitch = {payload_q[7], payload_q[6], payload_q[5], payload_q[4]};
	assign frame.yaw   = {payload_q[11], payload_q[10], payload_q[9], payload_q[8]};

endmodule

>>> rtl/core/iefp_conv_lane.sv
// one conversion lane: ieee single radians to saturating signed q16.16 degrees, four stages
// depends on iefp_pkg
module iefp_conv_lane import iefp_pkg::*; (
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [31:0] word,
	output logic [31:0] q16,
	output logic        sat
);

	typedef enum logic [1:0] {
		KIND_NORM,
		KIND_ZERO,
		KIND_SAT,
		KIND_NAN
	} kind_t;

	logic [7:0]  ex, ex_eff;
	logic [23:0] mant;
	kind_t       kind;
	logic [5:0]  shm1;

	kind_t       kind_s1, kind_s2, kind_s3;
	logic        sign_s1, sign_s2, sign_s3;
	logic [5:0]  shm1_s1, shm1_s2;
	logic [42:0] pp_hi_s1, pp_lo_s1;
	logic [61:0] prod_s2;
	logic [61:0] mag_s3;
	logic [61:0] shifted;

	logic [31:0] q16_d;
	logic        sat_d;

	assign ex     = word[30:23];
	assign ex_eff = (ex == 8'd0) ? 8'd1 : ex;
	assign mant   = (ex == 8'd0) ? {1'b0, word[22:0]} : {1'b1, word[22:0]};
	assign shm1   = 6'(8'd165 - ex_eff);

	always_comb begin
		priority if (ex == 8'hFF) begin
			kind = (word[22:0] != 23'd0) ? KIND_NAN : KIND_SAT;
		end else if (mant == 24'd0) begin
			kind = KIND_ZERO;
		end else if (ex_eff >= 8'd166) begin
			kind = KIND_SAT;
		end else if (ex_eff < 8'd104) begin
			kind = KIND_ZERO;
		end else begin
			kind = KIND_NORM;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			kind_s1  <= kind;
			sign_s1  <= word[31];
			shm1_s1  <= shm1;
			pp_hi_s1 <= {19'd0, mant} * {24'd0, K_HI};
			pp_lo_s1 <= {19'd0, mant} * {24'd0, K_LO};
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			kind_s2 <= kind_s1;
			sign_s2 <= sign_s1;
			shm1_s2 <= shm1_s1;
			prod_s2 <= ({19'd0, pp_hi_s1} << K_LO_W) + {19'd0, pp_lo_s1};
		end
	end

	assign shifted = prod_s2 >> shm1_s2;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			kind_s3 <= kind_s2;
			sign_s3 <= sign_s2;
			mag_s3  <= 62'(({1'b0, shifted} + 63'd1) >> 1);
		end
	end

	always_comb begin
		q16_d = '0;
		sat_d = 1'b0;
		unique case (kind_s3)
			KIND_NAN: begin
				sat_d = 1'b1;
			end
			KIND_ZERO: begin
				q16_d = '0;
			end
			KIND_SAT: begin
				q16_d = sign_s3 ? Q16_NEG_MAX : Q16_POS_MAX;
				sat_d = 1'b1;
			end
			KIND_NORM: begin
				if (sign_s3) begin
					if (mag_s3 > {30'd0, Q16_NEG_MAX}) begin
						q16_d = Q16_NEG_MAX;
						sat_d = 1'b1;
					end else begin
						q16_d = 32'd0 - mag_s3[31:0];
					end
				end else begin
					if (mag_s3 > {30'd0, Q16_POS_MAX}) begin
						q16_d = Q16_POS_MAX;
						sat_d = 1'b1;
					end else begin
						q16_d = mag_s3[31:0];
					end
				end
			end
			default: begin
				q16_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			q16 <= q16_d;
			sat <= sat_d;
		end
	end

endmodule

>>> rtl/core/iefp_checker.sv
// port-level checker for the euler frame parser, bound to the top level
// depends on imu_euler_frame_parser_unit_macros.svh
`include "imu_euler_frame_parser_unit_macros.svh"

module iefp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result transaction stays offered and unchanged
	`IEFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`IEFP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// input is only held off behind a waiting result
	`IEFP_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with no result waiting")
	`IEFP_ASSERT_NOW(a_drain_frees, m_tready, s_tready, "input stalled while output drains")

endmodule

bind imu_euler_frame_parser_unit iefp_checker u_iefp_checker (.*);
